// ===== rtl/tfds_pkg.sv =====
// Shared types and codes for the triangular fundamental diagram evaluator.
`timescale 1ns / 1ps

package tfds_pkg;

    // Operation codes carried by the op field.
    typedef enum logic [1:0] {
        OP_FLOW    = 2'd0,
        OP_DENSITY = 2'd1,
        OP_SPEED   = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // Flow modes for flow from density; any other code acts as plain.
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_DEMAND = 2'd1;
    localparam logic [1:0] MODE_SUPPLY = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_FREE_SPEED       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SPEED       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_JAM_DENSITY      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_DENSITY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY_FLOW    = 3'd4;

    // How the speed of a word is finally chosen.
    typedef enum logic [1:0] {
        SPD_ZERO = 2'd0,
        SPD_FREE = 2'd1,
        SPD_DIV  = 2'd2
    } speed_sel_t;

    // Control bits that follow a word down the pipeline.
    typedef struct packed {
        op_t  op;
        logic free_br;
        logic k_known;
        logic st;
    } ctrl_t;

endpackage

// ===== rtl/triangular_flow_density_speed.sv =====
// Triangular fundamental diagram: flow, density and speed in signed fixed point.
// Each word passes through the stage A register, the density divider, the speed divider and the output register.
// Throughput: one word per cycle while the pipeline is not stalled; two chains of one-bit division cells set the depth.
// The whole pipeline advances together whenever the output register is empty or being read.
// Reset clears all valid bits and sets every configuration register to zero.
`timescale 1ns / 1ps

module triangular_flow_density_speed #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tfds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]            cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       op,
    input  logic signed [DATA_WIDTH-1:0]     density_in,
    input  logic signed [DATA_WIDTH-1:0]     flow_in,
    input  logic [1:0]                       flow_mode,
    input  logic                             free_branch,
    input  logic                             density_known,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [DATA_WIDTH-1:0]     flow_out,
    output logic signed [DATA_WIDTH-1:0]     density_out,
    output logic signed [DATA_WIDTH-1:0]     speed_out,
    output logic                             status
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DVW  = W + F;
    localparam int PW   = 2 * W + 1;
    localparam int SATW = 2 * W + F + 1;
    localparam int CW   = $bits(tfds_pkg::ctrl_t);
    localparam int SB1W = CW + 2 + 2 * W;
    localparam int SB2W = 4 + 2 * W;

    localparam logic [W-1:0]    SMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]    SMIN     = {1'b1, {(W-1){1'b0}}};
    localparam logic [SATW-1:0] SMAX_EXT = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};

    // Saturate a magnitude with a sign into the signed data range.
    function automatic logic [W-1:0] sat_mag(input logic neg, input logic [SATW-1:0] m);
        logic [W-1:0] r;
        if (m > SMAX_EXT)
        begin
            r = neg ? SMIN : SMAX;
        end
        else
        begin
            r = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // Configuration registers.
    logic [W-2:0] free_speed_reg;
    logic [W-1:0] wave_speed_reg;
    logic [W-2:0] jam_density_reg;
    logic [W-2:0] critical_density_reg;
    logic [W-2:0] capacity_flow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_speed_reg       <= '0;
            wave_speed_reg       <= '0;
            jam_density_reg      <= '0;
            critical_density_reg <= '0;
            capacity_flow_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tfds_pkg::REG_FREE_SPEED:       free_speed_reg       <= cfg_data[W-2:0];
                tfds_pkg::REG_WAVE_SPEED:       wave_speed_reg       <= cfg_data;
                tfds_pkg::REG_JAM_DENSITY:      jam_density_reg      <= cfg_data[W-2:0];
                tfds_pkg::REG_CRITICAL_DENSITY: critical_density_reg <= cfg_data[W-2:0];
                tfds_pkg::REG_CAPACITY_FLOW:    capacity_flow_reg    <= cfg_data[W-2:0];
                default:                        ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage A: branch decode and the product for flow from density.
    tfds_pkg::op_t   op_in;
    tfds_pkg::ctrl_t a_ctrl_next;
    logic [1:0]      mode_eff;
    logic signed [W:0] k_x;
    logic signed [W:0] kc_x;
    logic signed [W:0] jam_x;
    logic signed [W:0] diff_x;
    logic [W:0]      diff_mag;
    logic [W-1:0]    mul_a;
    logic [W:0]      mul_b;
    logic            pneg_next;
    logic            cap_next;
    logic            below;
    logic            fact_next;
    logic            ferr;
    logic [PW-1:0]   prod_next;
    logic [W-1:0]    k_a_next;
    logic [W-1:0]    q_a_next;

    always_comb
    begin
        op_in     = tfds_pkg::op_t'(op);
        mode_eff  = (op_in == tfds_pkg::OP_SPEED) ? tfds_pkg::MODE_PLAIN : flow_mode;
        k_x       = {density_in[W-1], density_in};
        kc_x      = {2'b00, critical_density_reg};
        jam_x     = {2'b00, jam_density_reg};
        diff_x    = k_x - jam_x;
        diff_mag  = diff_x[W] ? (~diff_x + 1'b1) : diff_x;
        below     = (k_x <= kc_x);
        cap_next  = ((mode_eff == tfds_pkg::MODE_DEMAND) && (k_x > kc_x))
                 || ((mode_eff == tfds_pkg::MODE_SUPPLY) && (k_x < kc_x));
        fact_next = (op_in == tfds_pkg::OP_FLOW)
                 || ((op_in == tfds_pkg::OP_SPEED) && density_known);
        ferr      = fact_next && !cap_next && !below
                 && (jam_density_reg == critical_density_reg);
        if (below)
        begin
            mul_a     = {1'b0, free_speed_reg};
            mul_b     = {1'b0, mag(density_in)};
            pneg_next = density_in[W-1];
        end
        else
        begin
            mul_a     = mag(wave_speed_reg);
            mul_b     = diff_mag;
            pneg_next = wave_speed_reg[W-1] != diff_x[W];
        end
        prod_next = {{(W+1){1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
        k_a_next  = (op_in == tfds_pkg::OP_CLEAR) ? '0 : density_in;
        q_a_next  = (op_in == tfds_pkg::OP_CLEAR) ? '0 : flow_in;
        a_ctrl_next.op      = op_in;
        a_ctrl_next.free_br = free_branch;
        a_ctrl_next.k_known = density_known;
        a_ctrl_next.st      = ferr;
    end

    logic            a_valid_reg;
    tfds_pkg::ctrl_t a_ctrl_reg;
    logic            a_fact_reg;
    logic            a_cap_reg;
    logic            a_pneg_reg;
    logic [PW-1:0]   a_prod_reg;
    logic [W-1:0]    a_k_reg;
    logic [W-1:0]    a_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctrl_reg <= a_ctrl_next;
            a_fact_reg <= fact_next;
            a_cap_reg  <= cap_next;
            a_pneg_reg <= pneg_next;
            a_prod_reg <= prod_next;
            a_k_reg    <= k_a_next;
            a_q_reg    <= q_a_next;
        end
    end

    // Stage B: finish the flow, set up density from flow.
    tfds_pkg::ctrl_t b_ctrl;
    logic [W-1:0]    q1;
    logic            dact;
    logic            dneg;
    logic            derr;
    logic [W-1:0]    dsr1;
    logic [DVW-1:0]  dvd1;
    logic [SB1W-1:0] side1;

    always_comb
    begin
        if (!a_fact_reg)
        begin
            q1 = a_q_reg;
        end
        else if (a_cap_reg)
        begin
            q1 = {1'b0, capacity_flow_reg};
        end
        else if (a_ctrl_reg.st)
        begin
            q1 = '0;
        end
        else
        begin
            q1 = sat_mag(a_pneg_reg, SATW'(a_prod_reg >> F));
        end
        dact = (a_ctrl_reg.op == tfds_pkg::OP_DENSITY)
            || ((a_ctrl_reg.op == tfds_pkg::OP_SPEED) && !a_ctrl_reg.k_known);
        dsr1 = a_ctrl_reg.free_br ? {1'b0, free_speed_reg} : mag(wave_speed_reg);
        dneg = a_ctrl_reg.free_br ? a_q_reg[W-1] : (a_q_reg[W-1] != wave_speed_reg[W-1]);
        derr = dact && (dsr1 == '0);
        dvd1 = {mag(a_q_reg), {F{1'b0}}};
        b_ctrl    = a_ctrl_reg;
        b_ctrl.st = a_ctrl_reg.st || derr;
        side1 = {b_ctrl, dact, dneg, a_k_reg, q1};
    end

    logic            d1_valid;
    logic [DVW-1:0]  quo1;
    logic [W-1:0]    rem1;
    logic [SB1W-1:0] d1_side;

    tfds_div #(
        .DVW(DVW),
        .DSW(W),
        .SBW(SB1W)
    ) u_div_density (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (a_valid_reg),
        .dividend (dvd1),
        .divisor  (dsr1),
        .in_side  (side1),
        .out_valid(d1_valid),
        .quotient (quo1),
        .remainder(rem1),
        .out_side (d1_side)
    );

    // Stage C: finish the density, set up the speed division.
    tfds_pkg::ctrl_t    c_ctrl;
    logic               c_dact;
    logic               c_dneg;
    logic [W-1:0]       c_k;
    logic [W-1:0]       c_q;
    logic [W-1:0]       qd;
    logic [W:0]         sum;
    logic [W-1:0]       kd;
    logic [W-1:0]       k2;
    tfds_pkg::speed_sel_t vsel;
    logic [DVW-1:0]     dvd2;
    logic [SB2W-1:0]    side2;

    always_comb
    begin
        {c_ctrl, c_dact, c_dneg, c_k, c_q} = d1_side;
        qd  = sat_mag(c_dneg, SATW'(quo1));
        sum = {qd[W-1], qd} + {2'b00, jam_density_reg};
        if (sum[W] != sum[W-1])
        begin
            kd = sum[W] ? SMIN : SMAX;
        end
        else
        begin
            kd = sum[W-1:0];
        end
        if (c_ctrl.free_br)
        begin
            kd = qd;
        end
        if (!c_dact)
        begin
            k2 = c_k;
        end
        else if (c_ctrl.st)
        begin
            k2 = '0;
        end
        else
        begin
            k2 = kd;
        end
        // Speed is undefined on a zero flow unless the free branch has a density too.
        if ((c_ctrl.op != tfds_pkg::OP_SPEED) || c_ctrl.st)
        begin
            vsel = tfds_pkg::SPD_ZERO;
        end
        else if ((c_q == '0) && (!c_ctrl.free_br || (k2 == '0)))
        begin
            vsel = tfds_pkg::SPD_ZERO;
        end
        else if (k2[W-1] || (k2 == '0))
        begin
            vsel = tfds_pkg::SPD_FREE;
        end
        else
        begin
            vsel = tfds_pkg::SPD_DIV;
        end
        dvd2  = {mag(c_q), {F{1'b0}}};
        side2 = {vsel, c_ctrl.st, c_q[W-1], k2, c_q};
    end

    logic            d2_valid;
    logic [DVW-1:0]  quo2;
    logic [W-1:0]    rem2;
    logic [SB2W-1:0] d2_side;

    tfds_div #(
        .DVW(DVW),
        .DSW(W),
        .SBW(SB2W)
    ) u_div_speed (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d1_valid),
        .dividend (dvd2),
        .divisor  (k2),
        .in_side  (side2),
        .out_valid(d2_valid),
        .quotient (quo2),
        .remainder(rem2),
        .out_side (d2_side)
    );

    // Stage D: pick the speed and load the output register.
    tfds_pkg::speed_sel_t e_vsel;
    logic                 e_st;
    logic                 e_vneg;
    logic [W-1:0]         e_k;
    logic [W-1:0]         e_q;
    logic [W-1:0]         speed_next;

    always_comb
    begin
        {e_vsel, e_st, e_vneg, e_k, e_q} = d2_side;
        unique case (e_vsel)
            tfds_pkg::SPD_DIV:  speed_next = sat_mag(e_vneg, SATW'(quo2));
            tfds_pkg::SPD_FREE: speed_next = {1'b0, free_speed_reg};
            default:            speed_next = '0;
        endcase
    end

    logic [W-1:0] flow_reg;
    logic [W-1:0] density_reg;
    logic [W-1:0] speed_reg;
    logic         status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flow_reg    <= e_q;
            density_reg <= e_k;
            speed_reg   <= speed_next;
            status_reg  <= e_st;
        end
    end

    assign out_valid   = out_valid_reg;
    assign flow_out    = flow_reg;
    assign density_out = density_reg;
    assign speed_out   = speed_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    // A failed division leaves no speed.
    a_status_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (speed_out == '0))
        else $error("speed reported with division by zero status");

    // A failed derivation zeroes the field it was to produce.
    a_status_field: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> ((flow_out == '0) || (density_out == '0)))
        else $error("division by zero status with both flow and density set");

    // A stalled result is held by the output register.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(flow_out)
            && $stable(density_out) && $stable(speed_out) && $stable(status)))
        else $error("result changed while stalled");
`endif

endmodule

// ===== rtl/tfds_div_cell.sv =====
// One restoring division cell: produces one quotient bit per cycle while en is high.
`timescale 1ns / 1ps

module tfds_div_cell #(
    parameter int DVW = 48,
    parameter int DSW = 32,
    parameter int SBW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [DSW-1:0] in_rem,
    input  logic [DVW-1:0] in_acc,
    input  logic [DSW-1:0] in_dsr,
    input  logic [SBW-1:0] in_side,
    output logic           out_valid,
    output logic [DSW-1:0] out_rem,
    output logic [DVW-1:0] out_acc,
    output logic [DSW-1:0] out_dsr,
    output logic [SBW-1:0] out_side
);

    logic           valid_reg;
    logic [DSW-1:0] rem_reg;
    logic [DSW-1:0] rem_next;
    logic [DVW-1:0] acc_reg;
    logic [DVW-1:0] acc_next;
    logic [DSW-1:0] dsr_reg;
    logic [SBW-1:0] side_reg;
    logic [DSW:0]   trial;
    logic [DSW:0]   diff;
    logic           ge;

    // The accumulator shifts dividend bits out at the top and quotient bits in at the bottom.
    always_comb
    begin
        trial    = {in_rem, in_acc[DVW-1]};
        diff     = trial - {1'b0, in_dsr};
        ge       = (trial >= {1'b0, in_dsr});
        rem_next = ge ? diff[DSW-1:0] : trial[DSW-1:0];
        acc_next = {in_acc[DVW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            acc_reg  <= acc_next;
            dsr_reg  <= in_dsr;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;
    assign out_dsr   = dsr_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/tfds_div.sv =====
// Pipelined divider built as a chain of one-bit division cells.
`timescale 1ns / 1ps

module tfds_div #(
    parameter int DVW = 48,
    parameter int DSW = 32,
    parameter int SBW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    input  logic [SBW-1:0] in_side,
    output logic           out_valid,
    output logic [DVW-1:0] quotient,
    output logic [DSW-1:0] remainder,
    output logic [SBW-1:0] out_side
);

    logic           v   [0:DVW];
    logic [DSW-1:0] rem [0:DVW];
    logic [DVW-1:0] acc [0:DVW];
    logic [DSW-1:0] dsr [0:DVW];
    logic [SBW-1:0] sd  [0:DVW];

    assign v[0]   = in_valid;
    assign rem[0] = '0;
    assign acc[0] = dividend;
    assign dsr[0] = divisor;
    assign sd[0]  = in_side;

    for (genvar i = 0; i < DVW; i++)
    begin : g_cell
        tfds_div_cell #(
            .DVW(DVW),
            .DSW(DSW),
            .SBW(SBW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v[i]),
            .in_rem   (rem[i]),
            .in_acc   (acc[i]),
            .in_dsr   (dsr[i]),
            .in_side  (sd[i]),
            .out_valid(v[i+1]),
            .out_rem  (rem[i+1]),
            .out_acc  (acc[i+1]),
            .out_dsr  (dsr[i+1]),
            .out_side (sd[i+1])
        );
    end

    assign out_valid = v[DVW];
    assign quotient  = acc[DVW];
    assign remainder = rem[DVW];
    assign out_side  = sd[DVW];

endmodule
